// ===== hw/rtl/roi_motion_activity_trigger_unit_macros.svh =====
// assertion macros for the motion activity trigger checker
// each macro expects clk and rst_n in scope
`ifndef ROI_MOTION_ACTIVITY_TRIGGER_UNIT_MACROS_SVH
`define ROI_MOTION_ACTIVITY_TRIGGER_UNIT_MACROS_SVH

// same-cycle implication
`define RMAT_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RMAT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rmat_pkg.sv =====
// shared types and constants of the motion activity trigger
// no dependencies
package rmat_pkg;

    localparam int COORD_BITS    = 12;
    localparam int SIZE_BITS     = COORD_BITS + 1;
    localparam int SPAN_BITS     = COORD_BITS + 2;
    localparam int DIFF_BITS     = COORD_BITS + 3;
    localparam int PROD_BITS     = 2 * SIZE_BITS;
    localparam int SQ_BITS       = 2 * PROD_BITS;
    localparam int TALLY_BITS    = 25;
    localparam int Q16_BITS      = 17;
    localparam int QUO_BITS      = 16;
    localparam int PIX_BITS      = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 17;

    localparam logic [TALLY_BITS-1:0] TALLY_MAX = {TALLY_BITS{1'b1}};
    localparam logic [Q16_BITS-1:0]   Q16_ONE   = 17'h10000;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_AREA_LEFT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_AREA_TOP    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_AREA_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_AREA_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SHAPE_MODE  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD   = 3'd5;

    // reset values
    localparam logic [SIZE_BITS-1:0] RST_AREA_SIDE = 13'd64;
    localparam logic [Q16_BITS-1:0]  RST_THRESHOLD = 17'd32768;
    localparam logic [PROD_BITS-1:0] RST_AREA      = 26'd4096;
    localparam logic [SQ_BITS-1:0]   RST_AREA_SQ   = 52'd16777216;

    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [PIX_BITS-1:0]   pixel_value;
        logic                  frame_end;
    } in_item_t;

    typedef struct packed {
        logic [TALLY_BITS-1:0] active_count;
        logic [Q16_BITS-1:0]   activity_q16;
        logic                  bang;
    } out_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] area_left;
        logic [COORD_BITS-1:0] area_top;
        logic [SIZE_BITS-1:0]  area_width;
        logic [SIZE_BITS-1:0]  area_height;
        logic                  shape_mode;
        logic [Q16_BITS-1:0]   threshold_q16;
    } cfg_t;

    // classified word handed from front to back
    typedef struct packed {
        logic frame_end;
        logic hit;
    } qent_t;

endpackage

// ===== hw/rtl/rmat_queue.sv =====
// short fifo between the classify front and the tally back
// depends on rmat_pkg
module rmat_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  rmat_pkg::qent_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output rmat_pkg::qent_t pop_data
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    rmat_pkg::qent_t     slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/rmat_front.sv =====
// four-stage classifier: rectangle test, then exact ellipse test
// depends on rmat_pkg
module rmat_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_fire,
    input  rmat_pkg::in_item_t            item,
    input  rmat_pkg::cfg_t                cfg,
    input  logic [rmat_pkg::SQ_BITS-1:0]  area_sq,
    output logic                          advance,
    output logic                          push_valid,
    input  logic                          push_ready,
    output rmat_pkg::qent_t               push_data
);

    localparam int SB = rmat_pkg::SIZE_BITS;
    localparam int PB = rmat_pkg::PROD_BITS;
    localparam int QB = rmat_pkg::SQ_BITS;
    localparam int DB = rmat_pkg::DIFF_BITS;
    localparam int XB = rmat_pkg::SPAN_BITS;

    logic          s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic          s1_end_reg, s2_end_reg, s3_end_reg, s4_end_reg;
    logic          s1_hit_reg, s2_hit_reg, s3_hit_reg, s4_hit_reg;
    logic [SB-1:0] s1_dx_reg, s1_dy_reg;
    logic [PB-1:0] s2_a_reg, s2_b_reg;
    logic [QB-1:0] s3_a2_reg, s3_b2_reg;

    logic [XB-1:0] right_edge, bottom_edge;
    logic [DB-1:0] col2, row2, ctr_x, ctr_y;
    logic [DB-1:0] dx_full, dy_full;
    logic          in_x, in_y, hit_rect;
    logic [QB:0]   ell_sum;
    logic          in_ellipse, hit_final;

    assign advance = !s4_valid_reg || push_ready;

    // rectangle bounds and doubled distances from the center
    always_comb
    begin
        right_edge  = {2'b00, cfg.area_left} + {1'b0, cfg.area_width};
        bottom_edge = {2'b00, cfg.area_top} + {1'b0, cfg.area_height};
        in_x = (item.col >= cfg.area_left) && ({2'b00, item.col} < right_edge);
        in_y = (item.row >= cfg.area_top) && ({2'b00, item.row} < bottom_edge);
        hit_rect = !item.frame_end && (item.pixel_value != '0) && in_x && in_y;
        col2  = {2'b00, item.col, 1'b0};
        row2  = {2'b00, item.row, 1'b0};
        ctr_x = {2'b00, cfg.area_left, 1'b0} + {2'b00, cfg.area_width};
        ctr_y = {2'b00, cfg.area_top, 1'b0} + {2'b00, cfg.area_height};
        dx_full = (col2 >= ctr_x) ? col2 - ctr_x : ctr_x - col2;
        dy_full = (row2 >= ctr_y) ? row2 - ctr_y : ctr_y - row2;
    end

    // (dx*h)^2 + (dy*w)^2 <= (w*h)^2
    always_comb
    begin
        ell_sum    = {1'b0, s3_a2_reg} + {1'b0, s3_b2_reg};
        in_ellipse = (ell_sum <= {1'b0, area_sq});
        hit_final  = s3_hit_reg && (!cfg.shape_mode || in_ellipse);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= item_fire;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_end_reg <= item.frame_end;
            s1_hit_reg <= hit_rect;
            // inside the rectangle the distance never exceeds the side
            s1_dx_reg  <= dx_full[SB-1:0];
            s1_dy_reg  <= dy_full[SB-1:0];

            s2_end_reg <= s1_end_reg;
            s2_hit_reg <= s1_hit_reg;
            s2_a_reg   <= PB'(s1_dx_reg) * PB'(cfg.area_height);
            s2_b_reg   <= PB'(s1_dy_reg) * PB'(cfg.area_width);

            s3_end_reg <= s2_end_reg;
            s3_hit_reg <= s2_hit_reg;
            s3_a2_reg  <= QB'(s2_a_reg) * QB'(s2_a_reg);
            s3_b2_reg  <= QB'(s2_b_reg) * QB'(s2_b_reg);

            s4_end_reg <= s3_end_reg;
            s4_hit_reg <= hit_final;
        end
    end

    assign push_valid          = s4_valid_reg;
    assign push_data.frame_end = s4_end_reg;
    assign push_data.hit       = s4_hit_reg;

endmodule

// ===== hw/rtl/rmat_back.sv =====
// tally, frame-end division by area, threshold crossing and result register
// depends on rmat_pkg
module rmat_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  rmat_pkg::qent_t                 pop_data,
    input  logic [rmat_pkg::PROD_BITS-1:0]  area,
    input  logic [rmat_pkg::Q16_BITS-1:0]   threshold_q16,
    output logic                            result_valid,
    input  logic                            result_ready,
    output rmat_pkg::out_item_t             result
);

    localparam int TB = rmat_pkg::TALLY_BITS;
    localparam int AB = rmat_pkg::PROD_BITS;
    localparam int QB = rmat_pkg::Q16_BITS;
    localparam int DIV_STEPS = rmat_pkg::QUO_BITS;
    localparam int STEP_BITS = $clog2(DIV_STEPS);
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DIV_STEPS - 1);

    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_DIV = 2'd1;
    localparam logic [1:0] ST_FIN = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [TB-1:0]        tally_reg, tally_next;
    logic [QB-1:0]        act_reg, act_next;
    logic [AB-1:0]        rem_reg, rem_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic [QB-1:0]        last_act_reg, last_act_next;
    logic                 first_reg, first_next;
    logic                 res_valid_reg, res_valid_next;
    rmat_pkg::out_item_t  res_reg, res_next;

    logic [AB:0]          rem2;
    logic                 rem_fits;
    logic                 slot_free;
    logic                 bang;

    assign pop_ready    = (state_reg == ST_RUN);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        rem2      = {rem_reg, 1'b0};
        rem_fits  = (rem2 >= {1'b0, area});
        slot_free = !res_valid_reg || result_ready;
        bang      = !first_reg && (last_act_reg < threshold_q16)
                    && (act_reg >= threshold_q16);
    end

    always_comb
    begin
        state_next     = state_reg;
        tally_next     = tally_reg;
        act_next       = act_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        last_act_next  = last_act_reg;
        first_next     = first_reg;
        res_valid_next = res_valid_reg && !result_ready;
        res_next       = res_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (pop_valid)
                begin
                    if (!pop_data.frame_end)
                    begin
                        if (pop_data.hit && (tally_reg != rmat_pkg::TALLY_MAX))
                        begin
                            tally_next = tally_reg + 1'b1;
                        end
                    end
                    else if (area == '0)
                    begin
                        act_next   = '0;
                        state_next = ST_FIN;
                    end
                    else if (AB'(tally_reg) >= area)
                    begin
                        act_next   = rmat_pkg::Q16_ONE;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        // tally below area: quotient fits in 16 bits
                        act_next   = '0;
                        rem_next   = AB'(tally_reg);
                        step_next  = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next  = rem_fits ? AB'(rem2 - {1'b0, area}) : rem2[AB-1:0];
                act_next  = {act_reg[QB-2:0], rem_fits};
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    res_valid_next        = 1'b1;
                    res_next.active_count = tally_reg;
                    res_next.activity_q16 = act_reg;
                    res_next.bang         = bang;
                    tally_next            = '0;
                    last_act_next         = act_reg;
                    first_next            = 1'b0;
                    state_next            = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            tally_reg     <= '0;
            last_act_reg  <= '0;
            first_reg     <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tally_reg     <= tally_next;
            last_act_reg  <= last_act_next;
            first_reg     <= first_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        res_reg  <= res_next;
    end

endmodule

// ===== hw/rtl/roi_motion_activity_trigger_unit.sv =====
// top level of the motion activity trigger: config registers, front, queue, back
// pixel words: one per cycle unless a register write is pending or the front stalls;
// a frame-end word passes the front, the queue and the back, where the 16-step restoring
// divider for count/area may run, holding off the queue; the front stalls once it fills
// depends on rmat_pkg, rmat_front, rmat_queue, rmat_back
// reset: rectangle at 0,0 of 64 by 64, rectangle mode, threshold one half, tally cleared
module roi_motion_activity_trigger_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  rmat_pkg::in_item_t                   item,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output rmat_pkg::out_item_t                  result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rmat_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [rmat_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int CB = rmat_pkg::COORD_BITS;
    localparam int SB = rmat_pkg::SIZE_BITS;
    localparam int PB = rmat_pkg::PROD_BITS;
    localparam int QB = rmat_pkg::SQ_BITS;

    rmat_pkg::cfg_t  cfg_reg;
    logic [PB-1:0]   area_reg;
    logic [QB-1:0]   area_sq_reg;
    logic            front_advance;
    logic            item_fire;
    logic            push_valid, push_ready;
    rmat_pkg::qent_t push_data;
    logic            pop_valid, pop_ready;
    rmat_pkg::qent_t pop_data;

    assign cfg_ready  = 1'b1;
    // a pending register write holds off pixel words for that cycle
    assign item_ready = front_advance && !cfg_valid;
    assign item_fire  = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.area_left     <= '0;
            cfg_reg.area_top      <= '0;
            cfg_reg.area_width    <= rmat_pkg::RST_AREA_SIDE;
            cfg_reg.area_height   <= rmat_pkg::RST_AREA_SIDE;
            cfg_reg.shape_mode    <= 1'b0;
            cfg_reg.threshold_q16 <= rmat_pkg::RST_THRESHOLD;
            area_reg              <= rmat_pkg::RST_AREA;
            area_sq_reg           <= rmat_pkg::RST_AREA_SQ;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    rmat_pkg::REG_AREA_LEFT:   cfg_reg.area_left     <= cfg_data[CB-1:0];
                    rmat_pkg::REG_AREA_TOP:    cfg_reg.area_top      <= cfg_data[CB-1:0];
                    rmat_pkg::REG_AREA_WIDTH:  cfg_reg.area_width    <= cfg_data[SB-1:0];
                    rmat_pkg::REG_AREA_HEIGHT: cfg_reg.area_height   <= cfg_data[SB-1:0];
                    rmat_pkg::REG_SHAPE_MODE:  cfg_reg.shape_mode    <= cfg_data[0];
                    rmat_pkg::REG_THRESHOLD:
                        cfg_reg.threshold_q16 <= cfg_data[rmat_pkg::Q16_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
            // area is registered from the size registers and its square from the registered area
            area_reg    <= PB'(cfg_reg.area_width) * PB'(cfg_reg.area_height);
            area_sq_reg <= QB'(area_reg) * QB'(area_reg);
        end
    end

    rmat_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_fire  (item_fire),
        .item       (item),
        .cfg        (cfg_reg),
        .area_sq    (area_sq_reg),
        .advance    (front_advance),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rmat_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rmat_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .area          (area_reg),
        .threshold_q16 (cfg_reg.threshold_q16),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result)
    );

endmodule

// ===== hw/rtl/rmat_checker.sv =====
// port-level checks of the motion activity trigger, bound to the top level
// depends on rmat_pkg and roi_motion_activity_trigger_unit_macros.svh
`include "roi_motion_activity_trigger_unit_macros.svh"

module rmat_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_ready,
    input logic                cfg_valid,
    input logic                result_valid,
    input logic                result_ready,
    input rmat_pkg::out_item_t result
);

    // stalled result word holds
    `RMAT_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result word changed while stalled")

    // register writes and pixel words never share a cycle
    `RMAT_ASSERT_IMPL(a_cfg_blocks_items, cfg_valid, !item_ready, "pixel word taken during a register write")

    // activity saturates at one
    `RMAT_ASSERT_IMPL(a_activity_range, result_valid, result.activity_q16 <= rmat_pkg::Q16_ONE, "activity above one")

    // a crossing needs nonzero activity
    `RMAT_ASSERT_IMPL(a_bang_activity, result_valid && result.bang, result.activity_q16 != '0, "bang with zero activity")

    // empty frame gives zero activity
    `RMAT_ASSERT_IMPL(a_zero_count, result_valid && (result.active_count == '0), result.activity_q16 == '0, "activity without counted pixels")

endmodule

bind roi_motion_activity_trigger_unit rmat_checker u_rmat_checker (.*);
